// ----- rtl/tkpd_pkg.sv -----
package tkpd_pkg;

  // default width of the stored press times
  localparam int unsigned TIME_BITS_DEF = 8;

  // fixed field widths
  localparam int unsigned STAMP_W   = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned EV_W      = 4;

  // events per scan and queue sizing
  localparam int unsigned MAX_EVENTS  = 5;
  localparam int unsigned SLOT_W      = $clog2(MAX_EVENTS);
  localparam int unsigned CNT_W       = $clog2(MAX_EVENTS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [CFG_W-1:0] LONG_TICKS_RST  = 8'd3;
  localparam logic [CFG_W-1:0] COMBO_TICKS_RST = 8'd2;

  typedef enum logic [EV_W-1:0] {
    EV_SET_DOWN   = 4'd0,
    EV_SET_UP     = 4'd1,
    EV_SET_PRESS  = 4'd2,
    EV_SET_LONG   = 4'd3,
    EV_MOD_DOWN   = 4'd4,
    EV_MOD_UP     = 4'd5,
    EV_MOD_PRESS  = 4'd6,
    EV_MOD_LONG   = 4'd7,
    EV_BOTH_PRESS = 4'd8,
    EV_BOTH_LONG  = 4'd9
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_TICKS  = 2'd0,
    CFG_COMBO_TICKS = 2'd1
  } cfg_idx_e;

  // all events caused by one scan, in emit order
  typedef struct packed {
    logic [MAX_EVENTS-1:0][EV_W-1:0] codes;
    logic [CNT_W-1:0]                count;
  } bundle_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/tkpd_if.sv -----
interface tkpd_scan_if;
  import tkpd_pkg::*;

  logic               valid;
  logic               ready;
  logic               set_level;
  logic               set_confirm;
  logic               mod_level;
  logic               mod_confirm;
  logic [STAMP_W-1:0] time_now;

  modport source (
    output valid, set_level, set_confirm, mod_level, mod_confirm, time_now,
    input  ready
  );
  modport sink (
    input  valid, set_level, set_confirm, mod_level, mod_confirm, time_now,
    output ready
  );
endinterface

interface tkpd_event_if;
  import tkpd_pkg::*;

  logic            valid;
  logic            ready;
  logic [EV_W-1:0] event_code;
  logic            last_event;

  modport source (
    output valid, event_code, last_event,
    input  ready
  );
  modport sink (
    input  valid, event_code, last_event,
    output ready
  );
endinterface

// ----- rtl/tkpd_front.sv -----
module tkpd_front #(
  parameter int unsigned TIME_BITS = tkpd_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tkpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tkpd_pkg::CFG_W-1:0]  cfg_wdata_i,
  tkpd_scan_if.sink                   scan_i,
  input  tkpd_pkg::q_stat_t           qstat_i,
  output logic                        push_o,
  output tkpd_pkg::bundle_t           bundle_o
);
  import tkpd_pkg::*;

  localparam int unsigned CmpW = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;

  logic [CFG_W-1:0]     long_q, combo_q;
  logic                 set_held_q, set_held_d, mod_held_q, mod_held_d;
  logic [TIME_BITS-1:0] set_start_q, set_start_d, mod_start_q, mod_start_d;
  logic [CmpW-1:0]      stamp_ext;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] set_el, mod_el;
  logic                 set_dn, set_cf, mod_dn, mod_cf;
  logic                 set_new, mod_new;
  logic                 set_long, mod_long, set_combo, mod_combo;
  logic                 accept;

  // handshake: room in the queue is all the front needs
  assign scan_i.ready = !qstat_i.full;
  assign accept       = scan_i.valid && scan_i.ready;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q  <= LONG_TICKS_RST;
      combo_q <= COMBO_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LONG_TICKS:  long_q  <= cfg_wdata_i;
        CFG_COMBO_TICKS: combo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // decode the active-low key lines and the time stamp
  assign set_dn    = !scan_i.set_level;
  assign set_cf    = !scan_i.set_confirm;
  assign mod_dn    = !scan_i.mod_level;
  assign mod_cf    = !scan_i.mod_confirm;
  assign stamp_ext = CmpW'(scan_i.time_now);
  assign now       = stamp_ext[TIME_BITS-1:0];

  // next key state; a new press starts its timer at the current stamp
  assign set_new     = set_dn && !set_held_q && set_cf;
  assign mod_new     = mod_dn && !mod_held_q && mod_cf;
  assign set_held_d  = set_dn && (set_held_q || set_cf);
  assign mod_held_d  = mod_dn && (mod_held_q || mod_cf);
  assign set_start_d = set_new ? now : set_start_q;
  assign mod_start_d = mod_new ? now : mod_start_q;

  // wrapping elapsed time and threshold compares
  assign set_el    = now - set_start_d;
  assign mod_el    = now - mod_start_d;
  assign set_long  = CmpW'(set_el) >= CmpW'(long_q);
  assign mod_long  = CmpW'(mod_el) >= CmpW'(long_q);
  assign set_combo = CmpW'(set_el) >= CmpW'(combo_q);
  assign mod_combo = CmpW'(mod_el) >= CmpW'(combo_q);

  // build the event list for this scan
  always_comb begin
    logic [CNT_W-1:0] n;
    n = '0;
    bundle_o.codes = '0;
    // set key
    if (set_new) begin
      bundle_o.codes[n[SLOT_W-1:0]] = EV_SET_DOWN;
      n = n + 1'b1;
    end else if (set_dn && set_held_q) begin
      if (set_long) begin
        bundle_o.codes[n[SLOT_W-1:0]] = EV_SET_LONG;
        n = n + 1'b1;
      end
    end else if (!set_dn && set_held_q) begin
      bundle_o.codes[n[SLOT_W-1:0]] = EV_SET_UP;
      n = n + 1'b1;
      if (!set_long) begin
        bundle_o.codes[n[SLOT_W-1:0]] = EV_SET_PRESS;
        n = n + 1'b1;
        if (mod_held_q) begin
          bundle_o.codes[n[SLOT_W-1:0]] = EV_BOTH_PRESS;
          n = n + 1'b1;
        end
      end
    end
    // mod key, sees the updated set state
    if (mod_new) begin
      bundle_o.codes[n[SLOT_W-1:0]] = EV_MOD_DOWN;
      n = n + 1'b1;
    end else if (mod_dn && mod_held_q) begin
      if (mod_long) begin
        bundle_o.codes[n[SLOT_W-1:0]] = EV_MOD_LONG;
        n = n + 1'b1;
      end
    end else if (!mod_dn && mod_held_q) begin
      bundle_o.codes[n[SLOT_W-1:0]] = EV_MOD_UP;
      n = n + 1'b1;
      if (!mod_long) begin
        bundle_o.codes[n[SLOT_W-1:0]] = EV_MOD_PRESS;
        n = n + 1'b1;
        if (set_held_d) begin
          bundle_o.codes[n[SLOT_W-1:0]] = EV_BOTH_PRESS;
          n = n + 1'b1;
        end
      end
    end
    // both keys held long enough
    if (set_dn && set_held_d && mod_dn && mod_held_d && set_combo && mod_combo) begin
      bundle_o.codes[n[SLOT_W-1:0]] = EV_BOTH_LONG;
      n = n + 1'b1;
    end
    bundle_o.count = n;
  end

  // scans without events are dropped here
  assign push_o = accept && (bundle_o.count != '0);

  // key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_held_q  <= 1'b0;
      mod_held_q  <= 1'b0;
      set_start_q <= '0;
      mod_start_q <= '0;
    end else if (accept) begin
      set_held_q  <= set_held_d;
      mod_held_q  <= mod_held_d;
      set_start_q <= set_start_d;
      mod_start_q <= mod_start_d;
    end
  end

endmodule

// ----- rtl/tkpd_queue.sv -----
module tkpd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tkpd_pkg::bundle_t bundle_i,
  input  logic              pop_i,
  output tkpd_pkg::bundle_t head_o,
  output tkpd_pkg::q_stat_t stat_o
);
  import tkpd_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(QUEUE_DEPTH);

  bundle_t          entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  assign stat_o.full  = (fill_q == FillMax);
  assign stat_o.empty = (fill_q == '0);
  assign head_o       = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= bundle_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tkpd_back.sv -----
module tkpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tkpd_pkg::bundle_t head_i,
  input  tkpd_pkg::q_stat_t qstat_i,
  output logic              pop_o,
  tkpd_event_if.source      evt_o
);
  import tkpd_pkg::*;

  logic              vld_q, vld_d;
  logic [EV_W-1:0]   code_q;
  logic              last_q;
  logic [SLOT_W-1:0] sel_q, sel_d;
  logic              load, is_last;

  // load a new word when the output register is free or being taken
  assign load    = !qstat_i.empty && (!vld_q || evt_o.ready);
  assign is_last = (CNT_W'(sel_q) == CNT_W'(head_i.count - 1'b1));
  assign pop_o   = load && is_last;

  always_comb begin
    vld_d = vld_q;
    sel_d = sel_q;
    if (load) begin
      vld_d = 1'b1;
      sel_d = is_last ? '0 : sel_q + 1'b1;
    end else if (evt_o.ready) begin
      vld_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= '0;
    end else begin
      vld_q <= vld_d;
      sel_q <= sel_d;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= head_i.codes[sel_q];
      last_q <= is_last;
    end
  end

  assign evt_o.valid      = vld_q;
  assign evt_o.event_code = code_q;
  assign evt_o.last_event = last_q;

endmodule

// ----- rtl/two_key_press_event_detector_top.sv -----
// Two-key press event detector. Each scan word carries the active-low SET
// and MOD key levels, a debounce confirmation sample of each and a time
// stamp; the block tracks a held flag and press time per key and emits
// down, up, short press, long press and combined events as output words,
// one event per cycle while the receiver is ready, with last_event marking
// the final event of a scan. The front classifies a scan in the cycle it is
// taken and can take a scan every cycle while its two-entry queue has room;
// scans that cause no event leave no trace downstream. The back drains the
// queue event by event through a single output register; a queued scan
// holds 1 to 5 events. The user must write the two threshold registers
// only while idle; the block itself does not enforce this.
module two_key_press_event_detector_top #(
  parameter int unsigned TIME_BITS = tkpd_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tkpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tkpd_pkg::CFG_W-1:0]     cfg_wdata_i,
  tkpd_scan_if.sink                      scan_i,
  tkpd_event_if.source                   evt_o
);
  import tkpd_pkg::*;

  logic    push, pop;
  bundle_t bundle, head;
  q_stat_t qstat;

  // classify scans
  tkpd_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .scan_i      (scan_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .bundle_o    (bundle)
  );

  // event bundles in flight
  tkpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .head_o   (head),
    .stat_o   (qstat)
  );

  // serialize events
  tkpd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .evt_o   (evt_o)
  );

`ifndef SYNTHESIS
  // no bundle is written into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !qstat.full)
    else $error("push into full queue");

  // a pushed bundle holds between one and five events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (bundle.count != '0) && (bundle.count <= CNT_W'(MAX_EVENTS)))
    else $error("bad event count");

  // popping a bundle shows its final event next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> evt_o.valid && evt_o.last_event)
    else $error("pop without last event");

  // only defined event codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |-> (evt_o.event_code <= EV_BOTH_LONG))
    else $error("undefined event code");
`endif

endmodule
